[src/i2t_thermal_derate_core_assert.svh]
// Assertion macros shared by the thermal derate RTL
`ifndef I2T_THERMAL_DERATE_CORE_ASSERT_SVH
`define I2T_THERMAL_DERATE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define I2T_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2t assertion failed");

// Next-cycle implication, checked outside reset
`define I2T_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2t assertion failed");

`endif

[src/i2t_pkg.sv]
package i2t_pkg;

    typedef struct packed {
        logic signed [23:0] current_sample;
        logic [23:0]        elapsed_time;
    } i2t_in_t;

    typedef struct packed {
        logic [17:0] utilisation;
        logic [16:0] derate_factor;
        logic        over_temperature;
    } i2t_out_t;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ICONT  = 2'd1;
    localparam logic [1:0] CFG_TAU    = 2'd2;
    localparam logic [1:0] CFG_DBEGIN = 2'd3;

    localparam logic [16:0] Q_ONE         = 17'd65536;
    localparam logic [17:0] X_MAX         = 18'd262143;
    localparam logic [15:0] DBEGIN_RESET  = 16'd55706;
    localparam logic [15:0] DBEGIN_MAX    = 16'd64880;
    localparam logic [17:0] FAULT_SET_X   = 18'd68812;
    localparam logic [17:0] FAULT_CLR_X   = 18'd65536;

endpackage

[src/i2t_thermal_derate_core.sv]
// I2t winding thermal model with current derate and overtemperature latch.
// Input channel (in_valid/in_ready/in_data): one beat per control tick with a
// signed current sample in mA and the elapsed time in us. Output channel
// (out_valid/out_ready/out_data): one beat per input beat carrying the
// utilisation x (Q2.16), the derate multiplier (Q16) and the fault latch.
// Configuration: cfg_we/cfg_addr/cfg_wdata write enable, Icont, tau and the
// derate start point; write only while the block is idle.
// Sequencing: a cold-state beat goes straight to write-back; any other beat
// may pass through the shared bit-serial shift-add
// multiplier (24 steps for both squares, 17 for the lag product) and the
// shared radix-2 restoring divider (18 steps for the target, 16 for the lag
// weight, 16 for derate), between setup and write-back.
// One beat is worked on at a time; in_ready is high only while idle, so the
// next beat is taken only once the current one reaches the output register.
// The result sits in an output register, so a new beat is taken while the
// previous result still waits; a stalled receiver only holds back the next
// result from leaving the sequencer.
// Reset clears x and the latch, sets derate to 1.0, disables protection and
// loads the derate start point with 0.85.
module i2t_thermal_derate_core
    import i2t_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  i2t_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output i2t_out_t    out_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_TLOAD, ST_TDIV, ST_APREP, ST_ADIV,
        ST_MPREP, ST_MUL, ST_FIN, ST_DPREP, ST_DDIV, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration
    logic        enable_reg;
    logic [22:0] icont_reg;
    logic [31:0] tau_reg;
    logic [15:0] dbegin_reg;

    // thermal state
    logic [17:0] heat_reg;
    logic [16:0] mult_reg;
    logic        latch_reg;

    // datapath
    logic [4:0]         cnt_reg;
    logic [23:0]        dt_reg;
    logic [23:0]        mag_reg;
    logic [46:0]        mcand_a_reg;
    logic [46:0]        acc_a_reg;
    logic [22:0]        ic_reg;
    logic [45:0]        mcand_b_reg;
    logic [45:0]        acc_b_reg;
    logic [45:0]        rem_reg;
    logic [45:0]        div_reg;
    logic [17:0]        feed_reg;
    logic [17:0]        quo_reg;
    logic [17:0]        target_reg;
    logic [16:0]        a_reg;
    logic signed [36:0] delta_reg;
    logic signed [36:0] prod_reg;
    logic [17:0]        x_reg;

    i2t_out_t out_reg;
    logic     out_valid_reg;

    // one restoring division step
    logic [46:0] rem_shift;
    logic [47:0] rem_sub;
    logic        div_ge;
    logic [45:0] rem_step;
    logic [17:0] quo_step;

    assign rem_shift = {rem_reg, feed_reg[17]};
    assign rem_sub   = {1'b0, rem_shift} - {2'b00, div_reg};
    assign div_ge    = !rem_sub[47];
    assign rem_step  = div_ge ? rem_sub[45:0] : rem_shift[45:0];
    assign quo_step  = {quo_reg[16:0], div_ge};

    // input decode
    logic        cold_in;
    logic [23:0] mag_in;

    assign cold_in = !enable_reg || (icont_reg == 23'd0) || (in_data.elapsed_time == 24'd0);
    assign mag_in  = in_data.current_sample[23]
                   ? (~in_data.current_sample + 24'd1) : in_data.current_sample;

    // lag update: x + floor(a*(target-x)/65536)
    logic signed [21:0] lag_sum;
    logic signed [36:0] prod_shr;

    assign prod_shr = prod_reg >>> 16;
    assign lag_sum  = $signed({4'b0000, heat_reg}) + prod_shr[21:0];

    logic saturated;
    assign saturated = {1'b0, acc_a_reg} >= {acc_b_reg, 2'b00};

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            icont_reg     <= '0;
            tau_reg       <= '0;
            dbegin_reg    <= DBEGIN_RESET;
            heat_reg      <= '0;
            mult_reg      <= Q_ONE;
            latch_reg     <= 1'b0;
            cnt_reg       <= '0;
            dt_reg        <= '0;
            mag_reg       <= '0;
            mcand_a_reg   <= '0;
            acc_a_reg     <= '0;
            ic_reg        <= '0;
            mcand_b_reg   <= '0;
            acc_b_reg     <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            feed_reg      <= '0;
            quo_reg       <= '0;
            target_reg    <= '0;
            a_reg         <= '0;
            delta_reg     <= '0;
            prod_reg      <= '0;
            x_reg         <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_ENABLE: enable_reg <= cfg_wdata[0];
                    CFG_ICONT:  icont_reg  <= cfg_wdata[22:0];
                    CFG_TAU:    tau_reg    <= cfg_wdata;
                    CFG_DBEGIN: dbegin_reg <= (cfg_wdata[15:0] > DBEGIN_MAX)
                                              ? DBEGIN_MAX : cfg_wdata[15:0];
                    default:    ;
                endcase
            end

            // drop the result once taken, unless the next one is loaded now
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        dt_reg <= in_data.elapsed_time;
                        if (cold_in)
                        begin
                            heat_reg  <= '0;
                            mult_reg  <= Q_ONE;
                            latch_reg <= 1'b0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            mag_reg     <= mag_in;
                            mcand_a_reg <= {23'd0, mag_in};
                            acc_a_reg   <= '0;
                            ic_reg      <= icont_reg;
                            mcand_b_reg <= {23'd0, icont_reg};
                            acc_b_reg   <= '0;
                            cnt_reg     <= '0;
                            state_reg   <= ST_SQ;
                        end
                    end
                end
                ST_SQ:
                begin
                    // square I and Icont together, one multiplier bit a cycle
                    if (mag_reg[0])
                    begin
                        acc_a_reg <= acc_a_reg + mcand_a_reg;
                    end
                    if (ic_reg[0])
                    begin
                        acc_b_reg <= acc_b_reg + mcand_b_reg;
                    end
                    mag_reg     <= mag_reg >> 1;
                    ic_reg      <= ic_reg >> 1;
                    mcand_a_reg <= mcand_a_reg << 1;
                    mcand_b_reg <= mcand_b_reg << 1;
                    cnt_reg     <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd23)
                    begin
                        state_reg <= ST_TLOAD;
                    end
                end
                ST_TLOAD:
                begin
                    if (saturated)
                    begin
                        target_reg <= X_MAX;
                        state_reg  <= ST_APREP;
                    end
                    else
                    begin
                        rem_reg   <= {1'b0, acc_a_reg[46:2]};
                        feed_reg  <= {acc_a_reg[1:0], 16'd0};
                        div_reg   <= acc_b_reg;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_TDIV;
                    end
                end
                ST_TDIV:
                begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    feed_reg <= feed_reg << 1;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd17)
                    begin
                        target_reg <= quo_step;
                        state_reg  <= ST_APREP;
                    end
                end
                ST_APREP:
                begin
                    if (tau_reg == 32'd0)
                    begin
                        x_reg     <= target_reg;
                        state_reg <= ST_DPREP;
                    end
                    else if ({8'd0, dt_reg} >= tau_reg)
                    begin
                        a_reg     <= Q_ONE;
                        state_reg <= ST_MPREP;
                    end
                    else
                    begin
                        rem_reg   <= {22'd0, dt_reg};
                        div_reg   <= {14'd0, tau_reg};
                        feed_reg  <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_ADIV;
                    end
                end
                ST_ADIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        a_reg     <= {1'b0, quo_step[15:0]};
                        state_reg <= ST_MPREP;
                    end
                end
                ST_MPREP:
                begin
                    delta_reg <= $signed({19'd0, target_reg}) - $signed({19'd0, heat_reg});
                    prod_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    // a is unsigned, so add shifted signed delta per set bit
                    if (a_reg[0])
                    begin
                        prod_reg <= prod_reg + delta_reg;
                    end
                    a_reg     <= a_reg >> 1;
                    delta_reg <= delta_reg <<< 1;
                    cnt_reg   <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd16)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    priority if (lag_sum < 0)
                    begin
                        x_reg <= '0;
                    end
                    else if (lag_sum > $signed({4'b0000, X_MAX}))
                    begin
                        x_reg <= X_MAX;
                    end
                    else
                    begin
                        x_reg <= lag_sum[17:0];
                    end
                    state_reg <= ST_DPREP;
                end
                ST_DPREP:
                begin
                    heat_reg <= x_reg;
                    priority if (x_reg >= FAULT_SET_X)
                    begin
                        latch_reg <= 1'b1;
                    end
                    else if (x_reg < FAULT_CLR_X)
                    begin
                        latch_reg <= 1'b0;
                    end
                    priority if (x_reg <= {2'b00, dbegin_reg})
                    begin
                        mult_reg  <= Q_ONE;
                        state_reg <= ST_DONE;
                    end
                    else if (x_reg >= {1'b0, Q_ONE})
                    begin
                        mult_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rem_reg   <= {28'd0, ({1'b0, Q_ONE} - x_reg)};
                        div_reg   <= {29'd0, (Q_ONE - {1'b0, dbegin_reg})};
                        feed_reg  <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DDIV;
                    end
                end
                ST_DDIV:
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15)
                    begin
                        mult_reg  <= {1'b0, quo_step[15:0]};
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.utilisation      <= heat_reg;
                        out_reg.derate_factor    <= mult_reg;
                        out_reg.over_temperature <= latch_reg;
                        out_valid_reg            <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "i2t_thermal_derate_core_assert.svh"

    `I2T_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    `I2T_ASSERT_NOW(a_target_rem_below_div, clk, rst_n, state_reg == ST_TDIV,
        rem_reg < div_reg)
    `I2T_ASSERT_NOW(a_fault_means_no_drive, clk, rst_n,
        out_valid && out_data.over_temperature, out_data.derate_factor == 17'd0)
    `I2T_ASSERT_NOW(a_cool_means_full_drive, clk, rst_n,
        out_valid && (out_data.utilisation == 18'd0), out_data.derate_factor == Q_ONE)

endmodule

[tb/sv/i2t_thermal_derate_core_tb.sv]
`timescale 1ns / 100ps

module i2t_thermal_derate_core_tb;
    import i2t_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    i2t_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    i2t_out_t    out_data;

    i2t_thermal_derate_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Predictor copy of the registers and the thermal state
    logic        prot_on;
    logic [22:0] rated_ma;
    logic [31:0] tau_us;
    logic [15:0] knee_q16;
    logic [17:0] heat_x;
    logic [16:0] limit_mult;
    logic        hot_latch;

    i2t_in_t  pending_beats[$];
    i2t_out_t predicted_results[$];

    int   mismatches;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic stim_done;
    logic hold_off;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    // Mirror a register write into the predictor; derate start saturates at 0.99
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ENABLE: prot_on  = val[0];
            CFG_ICONT:  rated_ma = val[22:0];
            CFG_TAU:    tau_us   = val;
            CFG_DBEGIN: knee_q16 = (val[15:0] > DBEGIN_MAX) ? DBEGIN_MAX : val[15:0];
            default: ;
        endcase
    endtask

    // Advance the thermal model by one sample and return the expected beat
    function automatic i2t_out_t heat_step(input i2t_in_t b);
        logic [23:0]      mag;
        logic [127:0]     target;
        logic [63:0]      weight;
        logic signed [63:0] prod;
        logic signed [63:0] q;
        logic signed [63:0] x;
        i2t_out_t r;
        if (!prot_on || rated_ma == 0 || b.elapsed_time == 0) begin
            heat_x = '0;
            limit_mult = Q_ONE;
            hot_latch = 1'b0;
        end
        else begin
            mag = b.current_sample[23] ? -b.current_sample : b.current_sample;
            target = ({104'd0, mag} * mag * 128'd65536) / ({105'd0, rated_ma} * rated_ma);
            if (target > X_MAX)
                target = X_MAX;
            x = $signed({46'd0, heat_x});
            if (tau_us != 0) begin
                weight = ({40'd0, b.elapsed_time} * 64'd65536) / {32'd0, tau_us};
                if (weight > 65536)
                    weight = 65536;
                prod = $signed(weight) * ($signed(target[63:0]) - x);
                if (prod >= 0)
                    q = prod / 65536;
                else
                    q = -((-prod + 65535) / 65536);
                x = x + q;
            end
            else
                x = $signed(target[63:0]);
            if (x < 0)
                x = 0;
            if (x > X_MAX)
                x = X_MAX;
            heat_x = x[17:0];
            if (heat_x <= knee_q16)
                limit_mult = Q_ONE;
            else if (heat_x >= 65536)
                limit_mult = '0;
            else
                limit_mult = 17'(((64'd65536 - heat_x) * 64'd65536)
                                 / (64'd65536 - knee_q16));
            if (heat_x >= FAULT_SET_X)
                hot_latch = 1'b1;
            else if (heat_x < FAULT_CLR_X)
                hot_latch = 1'b0;
        end
        r.utilisation = heat_x;
        r.derate_factor = limit_mult;
        r.over_temperature = hot_latch;
        return r;
    endfunction

    // Driver: hold valid and payload until the beat is taken
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else begin
            if (in_valid && in_ready) begin
                predicted_results.push_back(heat_step(in_data));
                void'(pending_beats.pop_front());
            end
            // Offer the next beat; the queue head stays put until accepted
            if ((!in_valid || in_ready) ) begin
                if (pending_beats.size() > 0 && !hold_off
                    && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_beats[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        i2t_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else begin
            if (out_valid && out_ready) begin
                if (predicted_results.size() == 0)
                    report("unexpected beat", 0, 0);
                else begin
                    want = predicted_results.pop_front();
                    if (out_data.utilisation !== want.utilisation)
                        report("utilisation", out_data.utilisation, want.utilisation);
                    if (out_data.derate_factor !== want.derate_factor)
                        report("derate_factor", out_data.derate_factor, want.derate_factor);
                    if (out_data.over_temperature !== want.over_temperature)
                        report("over_temperature", out_data.over_temperature,
                               want.over_temperature);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: generous bound on the slowest legal run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic i2t_in_t rand_beat(input int max_ma);
        i2t_in_t b;
        int m;
        m = $urandom_range(max_ma);
        b.current_sample = 24'($urandom_range(1) ? -m : m);
        case ($urandom_range(9))
            0:       b.elapsed_time = '0;
            1:       b.elapsed_time = 24'($urandom());
            default: b.elapsed_time = 24'($urandom_range(4000, 1));
        endcase
        if ($urandom_range(49) == 0)
            b.current_sample = 24'($urandom());
        return b;
    endfunction

    task automatic drain;
        wait (pending_beats.size() == 0 && !in_valid);
        wait (predicted_results.size() == 0);
        repeat (120) @(posedge clk);
    endtask

    task automatic load(input int n, input int max_ma);
        repeat (n) pending_beats.push_back(rand_beat(max_ma));
    endtask

    initial begin
        i2t_in_t b;
        mismatches     = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done      = 1'b0;
        hold_off       = 1'b0;
        cfg_we         = 1'b0;
        cfg_addr       = CFG_ENABLE;
        cfg_wdata      = '0;
        prot_on        = 1'b0;
        rated_ma       = '0;
        tau_us         = '0;
        knee_q16       = DBEGIN_RESET;
        heat_x         = '0;
        limit_mult     = Q_ONE;
        hot_latch      = 1'b0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: disabled block first, then extremes with instant tracking
        b.current_sample = 24'sd1000; b.elapsed_time = 24'd100;
        pending_beats.push_back(b);
        drain();
        write_reg(CFG_ENABLE, 32'd1);
        write_reg(CFG_ICONT, 32'd1000);
        write_reg(CFG_TAU, 32'd0);
        write_reg(CFG_DBEGIN, 32'hFFFF);
        b.current_sample = 24'sh800000; b.elapsed_time = 24'hFFFFFF; pending_beats.push_back(b);
        b.current_sample = 24'sh7FFFFF; pending_beats.push_back(b);
        b.current_sample = 24'sd1020;   b.elapsed_time = 24'd1; pending_beats.push_back(b);
        b.current_sample = 24'sd1000;   pending_beats.push_back(b);
        b.current_sample = -24'sd1030;  pending_beats.push_back(b);
        b.current_sample = 24'sd999;    pending_beats.push_back(b);
        b.current_sample = 24'sd996;    pending_beats.push_back(b);
        b.current_sample = 24'sd1040;   b.elapsed_time = 24'd0; pending_beats.push_back(b);
        b.current_sample = 24'sd0;      b.elapsed_time = 24'd5; pending_beats.push_back(b);
        drain();
        write_reg(CFG_ICONT, 32'd0);
        b.current_sample = 24'sd500; pending_beats.push_back(b);
        drain();
        write_reg(CFG_ICONT, 32'h7FFFFF);
        write_reg(CFG_TAU, 32'hFFFFFFFF);
        write_reg(CFG_DBEGIN, 32'd0);
        b.current_sample = 24'sh7FFFFF; b.elapsed_time = 24'hFFFFFF; pending_beats.push_back(b);
        b.current_sample = -24'sd1;     b.elapsed_time = 24'd1;      pending_beats.push_back(b);
        drain();

        // Random phases across configurations and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            write_reg(CFG_ENABLE, (ph == 5) ? 32'd0 : 32'd1);
            write_reg(CFG_ICONT, (ph == 7) ? 32'd1 : $urandom_range(20000, 200));
            write_reg(CFG_TAU, (ph == 2) ? 32'd0 : $urandom_range(40000, 1000));
            write_reg(CFG_DBEGIN, (ph == 6) ? 32'd64880 : $urandom_range(65535, 30000));
            load(45, rated_ma * 5 / 4);
            // Pause the sender until the block has emptied, then carry on
            wait (pending_beats.size() == 0 && !in_valid);
            hold_off = 1'b1;
            wait (predicted_results.size() == 0);
            hold_off = 1'b0;
            load(45, (ph == 7) ? 8388607 : rated_ma * 2);
            drain();
        end
        stim_done = 1'b1;

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
